// ===== rtl/core/bsfd_pkg.sv =====
// Shared types and constants for the bit-sync and FEC mode detector.
package bsfd_pkg;

  localparam int unsigned SYNC_BITS = 48;
  localparam int unsigned MODE_BITS = 32;
  localparam int unsigned POS_BITS  = 16;
  localparam int unsigned CFG_BITS  = 48;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CNT_BITS  = 6;

  localparam logic [SYNC_BITS-1:0] SYNC_RESET  = 48'hEB90B433AAAA;
  localparam logic [MODE_BITS-1:0] MODE0_RESET = 32'h352EF853;
  localparam logic [MODE_BITS-1:0] MODE1_RESET = 32'h5898233E;
  localparam logic [MODE_BITS-1:0] MODE2_RESET = 32'hEE434E88;

  localparam logic [CFG_IDX_BITS-1:0] REG_SYNC  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE0 = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE1 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE2 = 2'd3;

  localparam logic [1:0] KIND_MODE    = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_NO_SYNC = 2'd2;
  localparam logic [1:0] KIND_SHORT   = 2'd3;

  localparam logic [1:0] FEC_MODE0   = 2'd0;
  localparam logic [1:0] FEC_MODE1   = 2'd1;
  localparam logic [1:0] FEC_MODE2   = 2'd2;
  localparam logic [1:0] FEC_UNKNOWN = 2'd3;

  typedef struct packed {
    logic bit_in;
    logic end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          fec_mode;
    logic [7:0]          data_byte;
    logic [POS_BITS-1:0] sync_position;
    logic                last;
  } out_beat_t;

  typedef struct packed {
    logic       sync_eq;
    logic [2:0] mode_eq;
  } cell_eq_t;

endpackage

// ===== rtl/core/bsfd_cell.sv =====
// One history cell: holds a stream bit, passes it on, compares the incoming bit.
module bsfd_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                clr_i,
  input  logic                bit_i,
  input  logic                sync_bit_i,
  input  logic [2:0]          mode_bits_i,
  output logic                bit_o,
  output bsfd_pkg::cell_eq_t  eq_o
);

  logic bit_q;
  logic bit_d;

  always_comb begin
    bit_d = bit_q;
    if (en_i) begin
      bit_d = clr_i ? 1'b0 : bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o          = bit_q;
  assign eq_o.sync_eq   = (bit_i == sync_bit_i);
  assign eq_o.mode_eq   = ~(mode_bits_i ^ {3{bit_i}});

endmodule

// ===== rtl/core/bit_sync_and_fec_mode_detector.sv =====
// Top level: bit-sync search, FEC mode word check and payload byte packing.
// A result beat is registered and appears in the cycle after the bit that causes it.
// Throughput: one bit per cycle unless stalled; the history is a 48-cell shift chain
// whose incoming bits are compared in parallel to the sync pattern and mode words.
// The output register refills while its beat is being taken, so no bubbles.
// Reset (rst_ni low, async): registers to defaults, history and stream state cleared.
module bit_sync_and_fec_mode_detector (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  bsfd_pkg::in_beat_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output bsfd_pkg::out_beat_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [bsfd_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [bsfd_pkg::CFG_BITS-1:0]         cfg_data_i
);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_MODE,
    PH_DATA
  } phase_e;

  localparam int unsigned SB = bsfd_pkg::SYNC_BITS;
  localparam int unsigned MB = bsfd_pkg::MODE_BITS;
  localparam int unsigned PB = bsfd_pkg::POS_BITS;
  localparam int unsigned CB = bsfd_pkg::CNT_BITS;

  logic [SB-1:0] sync_q;
  logic [MB-1:0] mode0_q, mode1_q, mode2_q;

  phase_e        phase_q, phase_d;
  logic [PB-1:0] seen_q, seen_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic [7:0]    acc_q, acc_d;

  logic                out_valid_q, out_valid_d;
  bsfd_pkg::out_beat_t out_q, out_d;

  logic                accept;
  logic                eos;
  logic [SB-1:0]       chain_bits;
  bsfd_pkg::cell_eq_t  cell_eq [SB];
  logic [SB-1:0]       sync_eq_v;
  logic [SB-1:0]       m0_eq_v, m1_eq_v, m2_eq_v;
  logic                sync_hit;

  logic                res_valid;
  bsfd_pkg::out_beat_t res;
  logic [PB-1:0]       seen_inc;
  logic [CB-1:0]       cnt_inc;
  logic [7:0]          acc_new;
  logic [3:0]          pad_sh;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign eos        = in_data_i.end_of_stream;

  // history chain, cell 0 holds the newest bit
  for (genvar i = 0; i < SB; i++) begin : g_cell
    logic       cell_in;
    logic [2:0] mbits;
    if (i == 0) begin : g_head
      assign cell_in = in_data_i.bit_in;
    end else begin : g_link
      assign cell_in = chain_bits[i-1];
    end
    if (i < MB) begin : g_mode
      assign mbits = {mode2_q[i], mode1_q[i], mode0_q[i]};
    end else begin : g_nomode
      assign mbits = 3'b000;
    end
    bsfd_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (accept),
      .clr_i       (eos),
      .bit_i       (cell_in),
      .sync_bit_i  (sync_q[i]),
      .mode_bits_i (mbits),
      .bit_o       (chain_bits[i]),
      .eq_o        (cell_eq[i])
    );
    assign sync_eq_v[i] = cell_eq[i].sync_eq;
    assign m0_eq_v[i]   = cell_eq[i].mode_eq[0];
    assign m1_eq_v[i]   = cell_eq[i].mode_eq[1];
    assign m2_eq_v[i]   = cell_eq[i].mode_eq[2];
  end

  assign sync_hit = &sync_eq_v;
  assign seen_inc = (seen_q != {PB{1'b1}}) ? seen_q + 1'b1 : seen_q;
  assign cnt_inc  = cnt_q + 1'b1;
  assign acc_new  = {acc_q[6:0], in_data_i.bit_in};
  assign pad_sh   = 4'd8 - cnt_inc[3:0];

  always_comb begin
    phase_d   = phase_q;
    seen_d    = seen_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    res_valid = 1'b0;
    res       = '0;
    if (accept) begin
      seen_d = seen_inc;
      case (phase_q)
        PH_MODE: begin
          cnt_d = cnt_inc;
          if (cnt_inc == CB'(MB)) begin
            res_valid         = 1'b1;
            res.kind          = bsfd_pkg::KIND_MODE;
            res.sync_position = pos_q;
            res.last          = eos;
            if (&m0_eq_v[MB-1:0]) begin
              res.fec_mode = bsfd_pkg::FEC_MODE0;
            end else if (&m1_eq_v[MB-1:0]) begin
              res.fec_mode = bsfd_pkg::FEC_MODE1;
            end else if (&m2_eq_v[MB-1:0]) begin
              res.fec_mode = bsfd_pkg::FEC_MODE2;
            end else begin
              res.fec_mode = bsfd_pkg::FEC_UNKNOWN;
            end
            phase_d = PH_DATA;
            cnt_d   = '0;
          end else if (eos) begin
            res_valid         = 1'b1;
            res.kind          = bsfd_pkg::KIND_SHORT;
            res.sync_position = pos_q;
            res.last          = 1'b1;
          end
        end
        PH_DATA: begin
          acc_d = acc_new;
          cnt_d = cnt_inc;
          if (cnt_inc == CB'(8) || eos) begin
            res_valid         = 1'b1;
            res.kind          = bsfd_pkg::KIND_BYTE;
            res.data_byte     = acc_new << pad_sh;
            res.sync_position = pos_q;
            res.last          = eos;
            acc_d             = '0;
            cnt_d             = '0;
          end
        end
        default: begin
          if (seen_inc >= PB'(SB) && sync_hit) begin
            pos_d   = (seen_inc == {PB{1'b1}}) ? seen_inc : seen_inc - PB'(SB);
            phase_d = PH_MODE;
            cnt_d   = '0;
            if (eos) begin
              res_valid         = 1'b1;
              res.kind          = bsfd_pkg::KIND_SHORT;
              res.sync_position = pos_d;
              res.last          = 1'b1;
            end
          end else if (eos) begin
            res_valid = 1'b1;
            res.kind  = bsfd_pkg::KIND_NO_SYNC;
            res.last  = 1'b1;
          end
        end
      endcase
      if (eos) begin
        phase_d = PH_SEARCH;
        seen_d  = '0;
        pos_d   = '0;
        cnt_d   = '0;
        acc_d   = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (accept && res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q      <= bsfd_pkg::SYNC_RESET;
      mode0_q     <= bsfd_pkg::MODE0_RESET;
      mode1_q     <= bsfd_pkg::MODE1_RESET;
      mode2_q     <= bsfd_pkg::MODE2_RESET;
      phase_q     <= PH_SEARCH;
      seen_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bsfd_pkg::REG_SYNC:  sync_q  <= cfg_data_i[SB-1:0];
          bsfd_pkg::REG_MODE0: mode0_q <= cfg_data_i[MB-1:0];
          bsfd_pkg::REG_MODE1: mode1_q <= cfg_data_i[MB-1:0];
          bsfd_pkg::REG_MODE2: mode2_q <= cfg_data_i[MB-1:0];
          default: ;
        endcase
      end
      phase_q     <= phase_d;
      seen_q      <= seen_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/bsfd_checker.sv =====
// Port-level checks for the bit-sync and FEC mode detector, bound to the top.
module bsfd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bsfd_pkg::out_beat_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output beat");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == bsfd_pkg::KIND_NO_SYNC ||
                    out_data_o.kind == bsfd_pkg::KIND_SHORT)
    |-> out_data_o.last)
    else $error("failure report not marked last");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.kind == bsfd_pkg::KIND_MODE || out_data_o.fec_mode == 2'd0) &&
      (out_data_o.kind == bsfd_pkg::KIND_BYTE || out_data_o.data_byte == 8'd0))
    else $error("unused result field not zero");

  a_no_sync_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == bsfd_pkg::KIND_NO_SYNC
    |-> out_data_o.sync_position == '0)
    else $error("no-sync report carries a position");

endmodule

bind bit_sync_and_fec_mode_detector bsfd_checker u_bsfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/bit_sync_and_fec_mode_detector_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the bit-sync and FEC mode detector: bit streams checked against a tracker.
module bit_sync_and_fec_mode_detector_tb;

  localparam int unsigned SB  = bsfd_pkg::SYNC_BITS;
  localparam int unsigned MB  = bsfd_pkg::MODE_BITS;
  localparam int unsigned PB  = bsfd_pkg::POS_BITS;
  localparam int unsigned CB  = bsfd_pkg::CFG_BITS;
  localparam int unsigned IB  = bsfd_pkg::CFG_IDX_BITS;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [PB-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {PH_SEARCH, PH_MODE, PH_PAYLOAD} scan_phase_e;

  typedef struct packed {
    int unsigned         lead;
    bit                  sync;
    int unsigned         mode_len;
    int unsigned         pick;
    int unsigned         pay_len;
    bit                  typed;
    bsfd_pkg::out_beat_t beat;
  } stream_row_t;

  localparam stream_row_t DIR_ROWS [13] = '{
    '{1,  1'b0, 0,  0, 0,  1'b1, '{bsfd_pkg::KIND_NO_SYNC, 2'd0, 8'd0, 16'd0, 1'b1}},
    '{47, 1'b0, 0,  0, 0,  1'b1, '{bsfd_pkg::KIND_NO_SYNC, 2'd0, 8'd0, 16'd0, 1'b1}},
    '{0,  1'b1, 0,  0, 0,  1'b1, '{bsfd_pkg::KIND_SHORT, 2'd0, 8'd0, 16'd0, 1'b1}},
    '{5,  1'b1, 0,  0, 0,  1'b1, '{bsfd_pkg::KIND_SHORT, 2'd0, 8'd0, 16'd5, 1'b1}},
    '{0,  1'b1, 1,  0, 0,  1'b1, '{bsfd_pkg::KIND_SHORT, 2'd0, 8'd0, 16'd0, 1'b1}},
    '{3,  1'b1, 31, 0, 0,  1'b1, '{bsfd_pkg::KIND_SHORT, 2'd0, 8'd0, 16'd3, 1'b1}},
    '{0,  1'b1, 32, 0, 0,  1'b1,
      '{bsfd_pkg::KIND_MODE, bsfd_pkg::FEC_MODE0, 8'd0, 16'd0, 1'b1}},
    '{2,  1'b1, 32, 1, 0,  1'b1,
      '{bsfd_pkg::KIND_MODE, bsfd_pkg::FEC_MODE1, 8'd0, 16'd2, 1'b1}},
    '{0,  1'b1, 32, 2, 0,  1'b1,
      '{bsfd_pkg::KIND_MODE, bsfd_pkg::FEC_MODE2, 8'd0, 16'd0, 1'b1}},
    '{0,  1'b1, 32, 3, 0,  1'b1,
      '{bsfd_pkg::KIND_MODE, bsfd_pkg::FEC_UNKNOWN, 8'd0, 16'd0, 1'b1}},
    '{1,  1'b1, 32, 0, 1,  1'b0, '0},
    '{4,  1'b1, 32, 2, 8,  1'b0, '0},
    '{0,  1'b1, 32, 1, 40, 1'b0, '0}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bsfd_pkg::in_beat_t  in_data;
  logic                out_valid;
  logic                out_stall;
  bsfd_pkg::out_beat_t out_data;
  logic                cfg_we;
  logic [IB-1:0]       cfg_idx;
  logic [CB-1:0]       cfg_data;

  // register copies and stream tracker state
  logic [SB-1:0]                     sync_reg;
  logic [MB-1:0]                     mode_regs [3];
  logic [SB-1:0]                     hist;
  scan_phase_e                       scan_phase;
  logic [PB-1:0]                     seen_cnt;
  logic [PB-1:0]                     found_pos;
  logic [MB-1:0]                     mode_sr;
  logic [bsfd_pkg::CNT_BITS-1:0]     phase_cnt;
  logic [7:0]                        byte_acc;

  bsfd_pkg::out_beat_t pending_beats [$];
  bit                  stream_bits [$];
  int unsigned errors     = 0;
  int unsigned bits_sent  = 0;
  int unsigned beats_seen = 0;
  int unsigned burst_left = 0;
  bit          hold_req   = 1'b0;

  bit_sync_and_fec_mode_detector dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic clear_stream();
    hist       = '0;
    scan_phase = PH_SEARCH;
    seen_cnt   = '0;
    found_pos  = '0;
    mode_sr    = '0;
    phase_cnt  = '0;
    byte_acc   = '0;
  endtask

  task automatic track_bit(input logic b, input logic eos, output bit got,
                           output bsfd_pkg::out_beat_t beat);
    got  = 1'b0;
    beat = '0;
    if (seen_cnt != POS_MAX) seen_cnt++;
    case (scan_phase)
      PH_MODE: begin
        mode_sr = {mode_sr[MB-2:0], b};
        phase_cnt++;
        if (phase_cnt >= MB) begin
          beat.kind = bsfd_pkg::KIND_MODE;
          if (mode_sr == mode_regs[0]) beat.fec_mode = bsfd_pkg::FEC_MODE0;
          else if (mode_sr == mode_regs[1]) beat.fec_mode = bsfd_pkg::FEC_MODE1;
          else if (mode_sr == mode_regs[2]) beat.fec_mode = bsfd_pkg::FEC_MODE2;
          else beat.fec_mode = bsfd_pkg::FEC_UNKNOWN;
          beat.sync_position = found_pos;
          beat.last = eos;
          got = 1'b1;
          scan_phase = PH_PAYLOAD;
          phase_cnt = '0;
        end else if (eos) begin
          beat.kind = bsfd_pkg::KIND_SHORT;
          beat.sync_position = found_pos;
          beat.last = 1'b1;
          got = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        byte_acc = {byte_acc[6:0], b};
        phase_cnt++;
        if (phase_cnt >= 8 || eos) begin
          beat.kind = bsfd_pkg::KIND_BYTE;
          beat.data_byte = byte_acc << (8 - phase_cnt);
          beat.sync_position = found_pos;
          beat.last = eos;
          got = 1'b1;
          byte_acc = '0;
          phase_cnt = '0;
        end
      end
      default: begin
        hist = {hist[SB-2:0], b};
        if (seen_cnt >= SB && hist == sync_reg) begin
          found_pos = (seen_cnt == POS_MAX) ? POS_MAX : PB'(seen_cnt - SB);
          scan_phase = PH_MODE;
          phase_cnt = '0;
          mode_sr = '0;
          if (eos) begin
            beat.kind = bsfd_pkg::KIND_SHORT;
            beat.sync_position = found_pos;
            beat.last = 1'b1;
            got = 1'b1;
          end
        end else if (eos) begin
          beat.kind = bsfd_pkg::KIND_NO_SYNC;
          beat.last = 1'b1;
          got = 1'b1;
        end
      end
    endcase
    if (eos) clear_stream();
  endtask

  task automatic write_reg(input logic [IB-1:0] idx, input logic [CB-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      bsfd_pkg::REG_SYNC:  sync_reg = val[SB-1:0];
      bsfd_pkg::REG_MODE0: mode_regs[0] = val[MB-1:0];
      bsfd_pkg::REG_MODE1: mode_regs[1] = val[MB-1:0];
      bsfd_pkg::REG_MODE2: mode_regs[2] = val[MB-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [SB-1:0] s, input logic [MB-1:0] m0,
                             input logic [MB-1:0] m1, input logic [MB-1:0] m2);
    write_reg(bsfd_pkg::REG_SYNC, CB'(s));
    write_reg(bsfd_pkg::REG_MODE0, CB'(m0));
    write_reg(bsfd_pkg::REG_MODE1, CB'(m1));
    write_reg(bsfd_pkg::REG_MODE2, CB'(m2));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_bit(input logic b, input logic eos, input bit use_typed,
                          input bsfd_pkg::out_beat_t typed_beat);
    bit                  got;
    bsfd_pkg::out_beat_t pred;
    in_valid <= 1'b1;
    in_data  <= '{bit_in: b, end_of_stream: eos};
    do @(posedge clk); while (in_stall !== 1'b0);
    bits_sent++;
    track_bit(b, eos, got, pred);
    if (got) pending_beats.push_back(use_typed ? typed_beat : pred);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic send_stream(input bit use_typed, input bsfd_pkg::out_beat_t typed_beat);
    int i;
    for (i = 0; i < stream_bits.size(); i++)
      send_bit(stream_bits[i], i == stream_bits.size() - 1,
               use_typed && (i == stream_bits.size() - 1), typed_beat);
  endtask

  task automatic push_bits(input logic [63:0] v, input int unsigned n);
    int i;
    for (i = int'(n) - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endtask

  task automatic push_noise(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) stream_bits.push_back(bit'($urandom_range(0, 1)));
  endtask

  function automatic logic [MB-1:0] pick_word(input int unsigned sel, input bit fixed);
    case (sel)
      0:       return mode_regs[0];
      1:       return mode_regs[1];
      2:       return mode_regs[2];
      default: return fixed ? '0 : MB'($urandom());
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic build_random_stream();
    int unsigned sel;
    int unsigned n;
    stream_bits.delete();
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      push_noise($urandom_range(0, 12));
      push_bits(64'(sync_reg), SB);
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31) : MB;
      push_bits(64'(pick_word($urandom_range(0, 3), 1'b0) >> (MB - n)), n);
      if (n == MB) push_noise($urandom_range(0, 40));
    end else if (sel == 7) begin
      // sync with one bit hit
      push_noise($urandom_range(0, 12));
      push_bits(64'(sync_reg ^ (48'd1 << $urandom_range(0, 47))), SB);
      push_noise($urandom_range(0, 40));
    end else if (sel == 8) begin
      push_noise($urandom_range(1, 60));
    end else begin
      n = $urandom_range(1, 47);
      push_bits(64'(sync_reg >> (SB - n)), n);
    end
  endtask

  task automatic run_random(input int unsigned min_bits, input int unsigned min_beats);
    int unsigned b0;
    int unsigned r0;
    b0 = bits_sent;
    r0 = beats_seen;
    while (bits_sent - b0 < min_bits || beats_seen - r0 < min_beats) begin
      build_random_stream();
      send_stream(1'b0, '0);
      if ($urandom_range(0, 5) == 0) drain();
    end
  endtask

  task automatic report_mismatch(input string what, input bsfd_pkg::out_beat_t want,
                                 input bsfd_pkg::out_beat_t got);
    errors++;
    if (errors <= 10)
      $display({"%s: expected kind=%0d fec=%0d byte=%02h pos=%0d last=%0d,",
                " got kind=%0d fec=%0d byte=%02h pos=%0d last=%0d"},
               what, want.kind, want.fec_mode, want.data_byte, want.sync_position,
               want.last, got.kind, got.fec_mode, got.data_byte, got.sync_position,
               got.last);
  endtask

  always @(posedge clk) begin : out_check
    bsfd_pkg::out_beat_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat", '0, out_data);
      end else begin
        want = pending_beats.pop_front();
        if (want.kind !== out_data.kind || want.fec_mode !== out_data.fec_mode ||
            want.data_byte !== out_data.data_byte ||
            want.sync_position !== out_data.sync_position || want.last !== out_data.last)
          report_mismatch("beat mismatch", want, out_data);
      end
    end
  end

  initial begin : rx_side
    int unsigned hold_left;
    int unsigned span_left;
    int unsigned style;
    int unsigned tick;
    logic        nxt;
    hold_left = 0;
    span_left = 0;
    style     = 0;
    tick      = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left != 0) hold_left--;
      else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (span_left == 0) begin
        style     = $urandom_range(0, 3);
        span_left = $urandom_range(16, 160);
      end
      span_left--;
      case (style)
        0:       nxt = 1'b0;
        1:       nxt = ($urandom_range(0, 3) == 0);
        2:       nxt = ($urandom_range(0, 3) != 0);
        default: nxt = (tick % 7) < 3;
      endcase
      out_stall <= (hold_left != 0) || nxt;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stim
    int unsigned   r;
    logic [MB-1:0] twin;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    rst_n    <= 1'b0;
    sync_reg     = bsfd_pkg::SYNC_RESET;
    mode_regs[0] = bsfd_pkg::MODE0_RESET;
    mode_regs[1] = bsfd_pkg::MODE1_RESET;
    mode_regs[2] = bsfd_pkg::MODE2_RESET;
    clear_stream();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < $size(DIR_ROWS); r++) begin
      stream_bits.delete();
      push_bits(64'd0, DIR_ROWS[r].lead);
      if (DIR_ROWS[r].sync) push_bits(64'(sync_reg), SB);
      push_bits(64'(pick_word(DIR_ROWS[r].pick, 1'b1) >> (MB - DIR_ROWS[r].mode_len)),
                DIR_ROWS[r].mode_len);
      push_noise(DIR_ROWS[r].pay_len);
      send_stream(DIR_ROWS[r].typed, DIR_ROWS[r].beat);
    end
    drain();

    // lowest mode wins when words are equal
    load_config('0, '0, '0, '1);
    run_random(30, 1);
    drain();

    load_config('1, '1, 32'h5A5A_5A5A, 32'h5A5A_5A5A);
    run_random(30, 1);
    drain();

    // long receiver hold-off while bits keep coming
    hold_req = 1'b1;
    load_config(SB'({$urandom(), $urandom()}), $urandom(), $urandom(), $urandom());
    run_random(30, 1);
    drain();

    twin = $urandom();
    load_config(SB'({$urandom(), $urandom()}), $urandom(), twin, twin);
    run_random(30, 1);
    drain();

    if (errors == 0 && pending_beats.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bsfd_pkg.sv
rtl/core/bsfd_cell.sv
rtl/core/bit_sync_and_fec_mode_detector.sv
rtl/core/bsfd_checker.sv
tb/sv/bit_sync_and_fec_mode_detector_tb.sv
